// ===== rtl/core/m4vt_pkg.sv =====
// Package for the 4x4 matrix by vector transform unit.
// Holds the sizes, the payload word types, the pipeline control struct and the
// reset values of the coefficient registers. Depends on nothing.
package m4vt_pkg;

   localparam int DIM         = 4;
   localparam int FRAC_BITS   = 16;
   localparam int VEC_LEN     = 4;
   localparam int NREGS       = 8;
   localparam int COEF_W      = 32;
   localparam int PROD_W      = 2 * COEF_W;
   localparam int SUM_W       = PROD_W + $clog2(DIM);
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int REG_SEL_W   = $clog2(NREGS);

   typedef logic signed [COEF_W-1:0] m4vt_word_type;

   typedef struct packed {
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] in_w;
   } m4vt_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               saturated;
   } m4vt_rsp_type;

   typedef struct packed {
      logic adv_mul;
      logic adv_sum;
   } m4vt_ctrl_type;

   localparam logic [CSR_DATA_W-1:0] CSR_RESET [NREGS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   localparam m4vt_word_type WORD_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam m4vt_word_type WORD_MIN = {1'b1, {(COEF_W-1){1'b0}}};

endpackage

// ===== rtl/core/m4vt_lane.sv =====
// One row lane of the transform: multiplies, sum, shift and saturation.
// Uses m4vt_pkg; instantiated once per matrix row by the top level.
module m4vt_lane
   import m4vt_pkg::*;
(
   input  logic          clock,
   input  m4vt_ctrl_type ctrl,
   input  m4vt_word_type coef_row [DIM],
   input  m4vt_word_type vec      [DIM],
   output m4vt_word_type lane_word,
   output logic          lane_sat
);

   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-COEF_W:0]    upper;
   logic                     fits;

   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         prod_in[c] = PROD_W'(coef_row[c]) * PROD_W'(vec[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_mul) begin
         for (int c = 0; c < DIM; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int c = 0; c < DIM; c++) begin
         sum_in = sum_in + SUM_W'(prod_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign shifted = sum_ff >>> FRAC_BITS;
   assign upper   = shifted[SUM_W-1:COEF_W-1];
   assign fits    = (&upper) || !(|upper);

   always_comb begin
      if (fits) begin
         lane_word = shifted[COEF_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         lane_word = WORD_MIN;
      end else begin
         lane_word = WORD_MAX;
      end
   end

   assign lane_sat = !fits;

endmodule

// ===== rtl/core/m4vt_merge.sv =====
// Merging stage: gathers the lane results into one result word, combines the
// saturation flags and holds the word in the output register. Uses m4vt_pkg.
module m4vt_merge
   import m4vt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          sum_valid,
   input  m4vt_word_type lane_word [DIM],
   input  logic          lane_sat  [DIM],
   output logic          adv_out,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output m4vt_rsp_type  rsp_data
);

   m4vt_word_type row_word [VEC_LEN];
   logic          sat_any;
   m4vt_rsp_type  rsp_data_in;
   m4vt_rsp_type  rsp_data_ff;
   logic          rsp_valid_ff;

   always_comb begin
      sat_any = 1'b0;
      for (int r = 0; r < VEC_LEN; r++) begin
         row_word[r] = '0;
      end
      for (int r = 0; r < DIM; r++) begin
         row_word[r] = lane_word[r];
         sat_any     = sat_any | lane_sat[r];
      end
      rsp_data_in.out_x     = row_word[0];
      rsp_data_in.out_y     = row_word[1];
      rsp_data_in.out_z     = row_word[2];
      rsp_data_in.out_w     = row_word[3];
      rsp_data_in.saturated = sat_any;
   end

   assign adv_out = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/matrix4x4_vector_transform_unit.sv =====
// Top level of the 4x4 matrix by vector transform unit.
// Holds the coefficient registers and the pipeline control; uses m4vt_pkg,
// m4vt_lane and m4vt_merge.
//
// Each word on the request channel is a signed Q16.16 four-vector; each word
// on the response channel carries the four rows of the column-major matrix
// multiplied by it, shifted right by the fraction bits (rounding toward minus
// infinity) and saturated to 32 bits, with a flag set when any row clipped.
// The unit takes one word per cycle while the response side is not stalled and
// passes it through one stage of 32x32 multipliers (one per coefficient, four
// per row lane), one stage summing each row, and the output register behind
// the shift and saturation. Each stage moves on whenever the stage behind it is
// empty or moving, so bubbles close up while the response side is stalled. The
// coefficients are written through the register port, index 0 to 7, each
// register holding two rows of one column; writes to other indices are
// dropped. Reset loads the identity matrix.
module matrix4x4_vector_transform_unit
   import m4vt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  m4vt_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output m4vt_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [CSR_DATA_W-1:0] csr_ff [NREGS];
   logic                  mul_valid_ff;
   logic                  sum_valid_ff;
   logic                  adv_out;
   m4vt_ctrl_type         ctrl;
   m4vt_word_type         vec_all   [VEC_LEN];
   m4vt_word_type         lane_word [DIM];
   logic                  lane_sat  [DIM];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREGS; i++) begin
            csr_ff[i] <= CSR_RESET[i];
         end
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(NREGS))) begin
         csr_ff[csr_index[REG_SEL_W-1:0]] <= csr_data;
      end
   end

   assign ctrl.adv_sum = !sum_valid_ff || adv_out;
   assign ctrl.adv_mul = !mul_valid_ff || ctrl.adv_sum;
   assign req_ready    = ctrl.adv_mul;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (ctrl.adv_mul) begin
            mul_valid_ff <= req_valid;
         end
         if (ctrl.adv_sum) begin
            sum_valid_ff <= mul_valid_ff;
         end
      end
   end

   assign vec_all[0] = req_data.in_x;
   assign vec_all[1] = req_data.in_y;
   assign vec_all[2] = req_data.in_z;
   assign vec_all[3] = req_data.in_w;

   for (genvar r = 0; r < DIM; r++) begin : g_row
      m4vt_word_type coef_row [DIM];
      m4vt_word_type vec      [DIM];

      for (genvar c = 0; c < DIM; c++) begin : g_col
         assign coef_row[c] = csr_ff[REG_SEL_W'(2 * c + r / 2)][(r % 2) * COEF_W +: COEF_W];
         assign vec[c]      = vec_all[c];
      end

      m4vt_lane u_lane (
         .clock     (clock),
         .ctrl      (ctrl),
         .coef_row  (coef_row),
         .vec       (vec),
         .lane_word (lane_word[r]),
         .lane_sat  (lane_sat[r])
      );
   end

   m4vt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid_ff),
      .lane_word (lane_word),
      .lane_sat  (lane_sat),
      .adv_out   (adv_out),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
